// File: design/cbp_pkg.sv
// shared constants, beat types and arithmetic helpers for the bezier point evaluator
package cbp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_POINTS = 1024;

    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int XW    = 32;
    localparam int YW    = 17;
    localparam int FW    = 17;

    localparam int T_W     = FRAC_BITS + 1;
    localparam int DIV_W   = $clog2(MAX_POINTS);
    localparam int NUM_W   = IDX_W + FRAC_BITS;
    localparam int REM0_W  = NUM_W - T_W;
    localparam int DIV_SPS = 2;
    localparam int DIV_STG = (T_W + DIV_SPS - 1) / DIV_SPS;

    localparam int PT_W   = XW + 2;
    localparam int DIFF_W = PT_W + 1;
    localparam int PROD_W = DIFF_W + T_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [T_W-1:0]           T_ONE     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [PROD_W-1:0] HALF_PROD = PROD_W'(1) <<< (FRAC_BITS - 1);

    localparam logic [XW-1:0]    RST_STRIP = 32'd0;
    localparam logic [XW-1:0]    RST_BOX   = 32'hFFFF_FFFF;
    localparam logic [FW-1:0]    RST_C1_X  = 17'd21845;
    localparam logic [FW-1:0]    RST_C1_Y  = 17'd43690;
    localparam logic [FW-1:0]    RST_C2_X  = 17'd43690;
    localparam logic [FW-1:0]    RST_C2_Y  = 17'd21845;
    localparam logic [CNT_W-1:0] RST_COUNT = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STRIP = 3'd0,
        REG_BOX   = 3'd1,
        REG_C1_X  = 3'd2,
        REG_C1_Y  = 3'd3,
        REG_C2_X  = 3'd4,
        REG_C2_Y  = 3'd5,
        REG_COUNT = 3'd6
    } t_cfg_reg;

    typedef logic signed [PT_W-1:0]   t_pt;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic [IDX_W-1:0] point_index;
    } t_pt_beat;

    typedef struct packed {
        logic [XW-1:0] x_pos;
        logic [YW-1:0] y_value;
        logic          index_out_of_range;
    } t_res_beat;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_beat;

    // configuration view; keeping it stable while items are in flight falls to the user
    typedef struct packed {
        t_pt              x0;
        t_pt              x1;
        t_pt              x2;
        t_pt              x3;
        logic [T_W-1:0]   y1;
        logic [T_W-1:0]   y2;
        logic [CNT_W-1:0] cnt;
        logic [DIV_W-1:0] dv;
        logic             cnt_le1;
    } t_cfg_view;

    typedef struct packed {
        logic [T_W-1:0] t;
        logic           oor;
    } t_side;

    function automatic logic [T_W-1:0] sat_unit(input logic [FW-1:0] v);
        if (v > FW'(T_ONE)) begin
            return T_ONE;
        end
        return T_W'(v);
    endfunction

    function automatic t_prod lerp_mul(input t_diff d, input logic [T_W-1:0] t);
        return d * $signed({1'b0, t});
    endfunction

    // a + floor((m + half) / 2^FRAC_BITS)
    function automatic t_pt lerp_round(input t_pt a, input t_prod m);
        t_prod s;
        s = m + HALF_PROD;
        return a + t_pt'(s >>> FRAC_BITS);
    endfunction

endpackage

// File: design/cbp_stream_if.sv
// valid/ready channel carrying one payload beat
interface cbp_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/cbp_cfg_regs.sv
// configuration registers and the registered control point x computation
module cbp_cfg_regs import cbp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbp_stream_if.sink i_cfg,
    output t_cfg_view o_view
);

    logic [XW-1:0]    r_strip;
    logic [XW-1:0]    r_box;
    logic [FW-1:0]    r_c1x;
    logic [FW-1:0]    r_c1y;
    logic [FW-1:0]    r_c2x;
    logic [FW-1:0]    r_c2y;
    logic [CNT_W-1:0] r_count;

    t_diff r_span;
    t_prod r_p1;
    t_prod r_p2;
    t_pt   r_x1;
    t_pt   r_x2;

    logic [CNT_W-1:0] cnt;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip <= RST_STRIP;
            r_box   <= RST_BOX;
            r_c1x   <= RST_C1_X;
            r_c1y   <= RST_C1_Y;
            r_c2x   <= RST_C2_X;
            r_c2y   <= RST_C2_Y;
            r_count <= RST_COUNT;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.payload.index))
                REG_STRIP: r_strip <= i_cfg.payload.data[XW-1:0];
                REG_BOX:   r_box   <= i_cfg.payload.data[XW-1:0];
                REG_C1_X:  r_c1x   <= i_cfg.payload.data[FW-1:0];
                REG_C1_Y:  r_c1y   <= i_cfg.payload.data[FW-1:0];
                REG_C2_X:  r_c2x   <= i_cfg.payload.data[FW-1:0];
                REG_C2_Y:  r_c2y   <= i_cfg.payload.data[FW-1:0];
                REG_COUNT: r_count <= i_cfg.payload.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // inner control x: span, product, round, each registered in turn after a write
    always_ff @(posedge i_clk) begin
        r_span <= DIFF_W'(r_box) - DIFF_W'(r_strip);
        r_p1   <= lerp_mul(r_span, sat_unit(r_c1x));
        r_p2   <= lerp_mul(r_span, sat_unit(r_c2x));
        r_x1   <= lerp_round(t_pt'(r_strip), r_p1);
        r_x2   <= lerp_round(t_pt'(r_strip), r_p2);
    end

    assign cnt = (r_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : r_count;

    always_comb begin
        o_view.x0      = t_pt'(r_strip);
        o_view.x1      = r_x1;
        o_view.x2      = r_x2;
        o_view.x3      = t_pt'(r_box);
        o_view.y1      = sat_unit(r_c1y);
        o_view.y2      = sat_unit(r_c2y);
        o_view.cnt     = cnt;
        o_view.dv      = DIV_W'(cnt - CNT_W'(1));
        o_view.cnt_le1 = (cnt <= CNT_W'(1));
    end

endmodule

// File: design/cbp_tdiv.sv
// index stage and pipelined restoring divider that produces the curve parameter t
module cbp_tdiv import cbp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbp_stream_if.sink i_pt,
    input  t_cfg_view i_cfg,
    output logic      o_valid,
    input  logic      i_ready,
    output t_side     o_side
);

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [T_W-1:0]   w;
        logic             oor;
        logic             one;
    } t_div_stg;

    t_div_stg           r_stg [DIV_STG+1];
    t_div_stg           n_stg [DIV_STG+1];
    logic [DIV_STG:0]   r_vld;
    logic [DIV_STG+1:0] en;
    logic [NUM_W-1:0]   num;

    // one quotient bit: shift in the next dividend bit, subtract when it fits
    function automatic t_div_stg div_step(input t_div_stg s, input logic [DIV_W-1:0] d);
        t_div_stg   n;
        logic [DIV_W:0] part;
        logic       qb;
        n    = s;
        part = {s.rem, s.w[T_W-1]};
        if (part >= {1'b0, d}) begin
            n.rem = DIV_W'(part - {1'b0, d});
            qb    = 1'b1;
        end else begin
            n.rem = part[DIV_W-1:0];
            qb    = 1'b0;
        end
        n.w = {s.w[T_W-2:0], qb};
        return n;
    endfunction

    always_comb begin
        en[DIV_STG+1] = i_ready;
        for (int k = DIV_STG; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_pt.ready = en[0];

    assign num = {i_pt.payload.point_index, {FRAC_BITS{1'b0}}} + NUM_W'(i_cfg.dv >> 1);

    always_comb begin
        n_stg[0].oor = CNT_W'(i_pt.payload.point_index) >= i_cfg.cnt;
        n_stg[0].one = n_stg[0].oor || i_cfg.cnt_le1;
        n_stg[0].rem = DIV_W'(num[NUM_W-1:T_W]);
        n_stg[0].w   = num[T_W-1:0];
        for (int k = 1; k <= DIV_STG; k++) begin
            n_stg[k] = r_stg[k-1];
            for (int j = 0; j < DIV_SPS; j++) begin
                if ((k - 1) * DIV_SPS + j < T_W) begin
                    n_stg[k] = div_step(n_stg[k], i_cfg.dv);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pt.valid;
            end
            for (int k = 1; k <= DIV_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= DIV_STG; k++) begin
            if (en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_valid    = r_vld[DIV_STG];
    assign o_side.t   = r_stg[DIV_STG].one ? T_ONE : r_stg[DIV_STG].w;
    assign o_side.oor = r_stg[DIV_STG].oor;

endmodule

// File: design/cbp_lerp_level.sv
// one de casteljau level: difference, multiply by t, round and add, for x and y lanes
module cbp_lerp_level import cbp_pkg::*; #(
    parameter int LANES = 1
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_side i_side,
    input  t_pt   i_px [LANES+1],
    input  t_pt   i_py [LANES+1],
    output logic  o_valid,
    input  logic  i_ready,
    output t_side o_side,
    output t_pt   o_px [LANES],
    output t_pt   o_py [LANES]
);

    logic [2:0] r_vld;
    logic [3:0] en;
    t_side      r_side [3];

    t_pt   r_ax  [LANES];
    t_pt   r_ay  [LANES];
    t_diff r_dx  [LANES];
    t_diff r_dy  [LANES];
    t_pt   r_ax2 [LANES];
    t_pt   r_ay2 [LANES];
    t_prod r_mx  [LANES];
    t_prod r_my  [LANES];
    t_pt   r_rx  [LANES];
    t_pt   r_ry  [LANES];

    always_comb begin
        en[3] = i_ready;
        for (int k = 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            if (en[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (en[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_side[0] <= i_side;
            for (int j = 0; j < LANES; j++) begin
                r_ax[j] <= i_px[j];
                r_ay[j] <= i_py[j];
                r_dx[j] <= DIFF_W'(i_px[j+1]) - DIFF_W'(i_px[j]);
                r_dy[j] <= DIFF_W'(i_py[j+1]) - DIFF_W'(i_py[j]);
            end
        end
        if (en[1]) begin
            r_side[1] <= r_side[0];
            for (int j = 0; j < LANES; j++) begin
                r_ax2[j] <= r_ax[j];
                r_ay2[j] <= r_ay[j];
                r_mx[j]  <= lerp_mul(r_dx[j], r_side[0].t);
                r_my[j]  <= lerp_mul(r_dy[j], r_side[0].t);
            end
        end
        if (en[2]) begin
            r_side[2] <= r_side[1];
            for (int j = 0; j < LANES; j++) begin
                r_rx[j] <= lerp_round(r_ax2[j], r_mx[j]);
                r_ry[j] <= lerp_round(r_ay2[j], r_my[j]);
            end
        end
    end

    assign o_valid = r_vld[2];
    assign o_side  = r_side[2];
    assign o_px    = r_rx;
    assign o_py    = r_ry;

endmodule

// File: design/cubic_bezier_point.sv
// top level: one cubic bezier curve point per accepted index beat
// a result is registered through the index stage, the divider, the three levels and the output register
// throughput: one beat per cycle while the result channel is not stalled; set by the 9-stage divider for t and
//   three interpolation levels of 3 stages each, every stage taking one beat a cycle
// reset: clears all valid bits and loads the configuration reset values
// control x points are registered through span, product and round after a configuration write
module cubic_bezier_point import cbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbp_stream_if.sink   i_pt,
    cbp_stream_if.sink   i_cfg,
    cbp_stream_if.source o_res
);

    t_cfg_view view;

    logic  dv_valid;
    logic  dv_ready;
    t_side dv_side;

    logic  l1_valid, l1_ready, l2_valid, l2_ready, l3_valid, l3_ready;
    t_side l1_side, l2_side, l3_side;

    t_pt l1_px [4];
    t_pt l1_py [4];
    t_pt l2_px [3];
    t_pt l2_py [3];
    t_pt l3_px [2];
    t_pt l3_py [2];
    t_pt fx    [1];
    t_pt fy    [1];

    logic      r_ov;
    t_res_beat r_res;
    logic      out_en;

    cbp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_view  (view)
    );

    cbp_tdiv u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .i_cfg   (view),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_side  (dv_side)
    );

    assign l1_px[0] = view.x0;
    assign l1_px[1] = view.x1;
    assign l1_px[2] = view.x2;
    assign l1_px[3] = view.x3;
    assign l1_py[0] = t_pt'(T_ONE);
    assign l1_py[1] = t_pt'(view.y1);
    assign l1_py[2] = t_pt'(view.y2);
    assign l1_py[3] = '0;

    cbp_lerp_level #(.LANES(3)) u_lvl1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv_valid),
        .o_ready (dv_ready),
        .i_side  (dv_side),
        .i_px    (l1_px),
        .i_py    (l1_py),
        .o_valid (l1_valid),
        .i_ready (l1_ready),
        .o_side  (l1_side),
        .o_px    (l2_px),
        .o_py    (l2_py)
    );

    cbp_lerp_level #(.LANES(2)) u_lvl2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (l1_valid),
        .o_ready (l1_ready),
        .i_side  (l1_side),
        .i_px    (l2_px),
        .i_py    (l2_py),
        .o_valid (l2_valid),
        .i_ready (l2_ready),
        .o_side  (l2_side),
        .o_px    (l3_px),
        .o_py    (l3_py)
    );

    cbp_lerp_level #(.LANES(1)) u_lvl3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (l2_valid),
        .o_ready (l2_ready),
        .i_side  (l2_side),
        .i_px    (l3_px),
        .i_py    (l3_py),
        .o_valid (l3_valid),
        .i_ready (l3_ready),
        .o_side  (l3_side),
        .o_px    (fx),
        .o_py    (fy)
    );

    // output register, saturates into the result fields
    assign out_en   = !r_ov || o_res.ready;
    assign l3_ready = out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_en) begin
            r_ov <= l3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            if (fx[0][PT_W-1]) begin
                r_res.x_pos <= '0;
            end else if (fx[0] > t_pt'({XW{1'b1}})) begin
                r_res.x_pos <= '1;
            end else begin
                r_res.x_pos <= fx[0][XW-1:0];
            end
            if (fy[0][PT_W-1]) begin
                r_res.y_value <= '0;
            end else if (fy[0] > t_pt'({YW{1'b1}})) begin
                r_res.y_value <= '1;
            end else begin
                r_res.y_value <= fy[0][YW-1:0];
            end
            r_res.index_out_of_range <= l3_side.oor;
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.payload = r_res;

endmodule

// File: tb/cubic_bezier_point_test.sv
// testbench for the cubic bezier point evaluator: directed corners, then random curves
module cubic_bezier_point_test;
    import cbp_pkg::*;

    localparam int    RANDOM_ITEMS = 1250;
    localparam int    TAIL_CYCLES  = 40;
    localparam longint UNIT      = longint'(1) << FRAC_BITS;
    localparam longint HALF_UNIT = longint'(1) << (FRAC_BITS - 1);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [XW-1:0] X_MAX = {XW{1'b1}};
    localparam logic [YW-1:0] Y_MAX = {YW{1'b1}};

    logic i_clk;
    logic i_rst_n;

    cbp_stream_if #(.t_payload(t_pt_beat))  point_bus ();
    cbp_stream_if #(.t_payload(t_cfg_beat)) cfg_bus ();
    cbp_stream_if #(.t_payload(t_res_beat)) result_bus ();

    cubic_bezier_point dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (point_bus),
        .i_cfg   (cfg_bus),
        .o_res   (result_bus)
    );

    // shadow copy of the register file
    logic [XW-1:0]    cfg_strip = RST_STRIP;
    logic [XW-1:0]    cfg_box   = RST_BOX;
    logic [FW-1:0]    cfg_c1x   = RST_C1_X;
    logic [FW-1:0]    cfg_c1y   = RST_C1_Y;
    logic [FW-1:0]    cfg_c2x   = RST_C2_X;
    logic [FW-1:0]    cfg_c2y   = RST_C2_Y;
    logic [CNT_W-1:0] cfg_count = RST_COUNT;

    t_res_beat pending_points[$];

    int  errors          = 0;
    int  checked         = 0;
    int  flagged         = 0;
    int  register_writes = 0;
    int  stall_left      = 0;
    bit  gaps_on         = 1'b0;
    bit  stalls_on       = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint unit_clamp(input logic [FW-1:0] v);
        return (v > UNIT) ? UNIT : longint'(v);
    endfunction

    // a + floor(((b - a) * t + half) / 2^FRAC_BITS)
    function automatic longint blend(input longint a, input longint b, input longint t);
        return a + (((b - a) * t + HALF_UNIT) >>> FRAC_BITS);
    endfunction

    function automatic longint casteljau(input longint p0, input longint p1,
                                         input longint p2, input longint p3,
                                         input longint t);
        longint a01, a12, a23;
        a01 = blend(p0, p1, t);
        a12 = blend(p1, p2, t);
        a23 = blend(p2, p3, t);
        return blend(blend(a01, a12, t), blend(a12, a23, t), t);
    endfunction

    function automatic t_res_beat curve_point(input logic [IDX_W-1:0] idx);
        t_res_beat r;
        longint    cnt, d, t, strip, box, span, x1, x2, x, y;
        cnt   = (cfg_count > MAX_POINTS) ? MAX_POINTS : longint'(cfg_count);
        strip = longint'({32'd0, cfg_strip});
        box   = longint'({32'd0, cfg_box});
        span  = box - strip;
        r.index_out_of_range = (longint'(idx) >= cnt);
        if (r.index_out_of_range || cnt <= 1) begin
            t = UNIT;
        end else begin
            d = cnt - 1;
            t = ((longint'(idx) << FRAC_BITS) + (d >> 1)) / d;
        end
        x1 = strip + ((span * unit_clamp(cfg_c1x) + HALF_UNIT) >>> FRAC_BITS);
        x2 = strip + ((span * unit_clamp(cfg_c2x) + HALF_UNIT) >>> FRAC_BITS);
        x  = casteljau(strip, x1, x2, box, t);
        y  = casteljau(UNIT, unit_clamp(cfg_c1y), unit_clamp(cfg_c2y), 0, t);
        if (x < 0) x = 0;
        if (x > longint'({32'd0, X_MAX})) x = longint'({32'd0, X_MAX});
        if (y < 0) y = 0;
        if (y > longint'(Y_MAX)) y = longint'(Y_MAX);
        r.x_pos   = x[XW-1:0];
        r.y_value = y[YW-1:0];
        return r;
    endfunction

    // fraction or y value, sometimes past 1.0, sometimes with junk above the field
    function automatic logic [CFG_DATA_W-1:0] frac_value();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = CFG_DATA_W'(UNIT);
            2:       v = $urandom_range(32'(UNIT + 1), 32'(2 * UNIT - 1));
            default: v = $urandom_range(0, 32'(UNIT));
        endcase
        if ($urandom_range(0, 3) == 0) v = v | ($urandom & ~32'h1_FFFF);
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] width_value();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return X_MAX;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_field(input string name, input logic [XW-1:0] want,
                                input logic [XW-1:0] got);
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res_beat want;
        t_res_beat got;
        if (i_rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
            got = result_bus.payload;
            if (pending_points.size() == 0) begin
                $display("%0t unexpected curve point beat: x=%0d y=%0d flag=%0b",
                         $time, got.x_pos, got.y_value, got.index_out_of_range);
                errors++;
            end else begin
                want = pending_points.pop_front();
                checked++;
                if (want.index_out_of_range) flagged++;
                if (got.x_pos !== want.x_pos)
                    report_field("x_pos", want.x_pos, got.x_pos);
                if (got.y_value !== want.y_value)
                    report_field("y_value", XW'(want.y_value), XW'(got.y_value));
                if (got.index_out_of_range !== want.index_out_of_range)
                    report_field("index_out_of_range", XW'(want.index_out_of_range),
                                 XW'(got.index_out_of_range));
            end
        end
    end

    // result backpressure in random bursts
    always @(negedge i_clk) begin
        if (stalls_on && stall_left != 0) begin
            stall_left <= stall_left - 1;
            result_bus.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 17);
            result_bus.ready <= 1'b0;
        end else begin
            stall_left <= 0;
            result_bus.ready <= 1'b1;
        end
    end

    task automatic send_point(input logic [IDX_W-1:0] idx);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            point_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        point_bus.valid   <= 1'b1;
        point_bus.payload <= '{point_index: idx};
        do @(posedge i_clk); while (point_bus.ready !== 1'b1);
        pending_points = {pending_points, curve_point(idx)};
    endtask

    // drop the index channel and let every expected point come back
    task automatic wait_drained();
        @(negedge i_clk);
        point_bus.valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid   <= 1'b1;
        cfg_bus.payload <= '{index: idx, data: data};
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        case (idx)
            REG_STRIP: cfg_strip = data[XW-1:0];
            REG_BOX:   cfg_box   = data[XW-1:0];
            REG_C1_X:  cfg_c1x   = data[FW-1:0];
            REG_C1_Y:  cfg_c1y   = data[FW-1:0];
            REG_C2_X:  cfg_c2x   = data[FW-1:0];
            REG_C2_Y:  cfg_c2y   = data[FW-1:0];
            REG_COUNT: cfg_count = data[CNT_W-1:0];
            default: ;
        endcase
        register_writes++;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // reset shape: start point, middle, end point
    task automatic test_reset_shape();
        send_point(0);
        send_point(1);
        send_point(511);
        send_point(512);
        send_point(1023);
    endtask

    task automatic test_count_corners();
        wait_drained();
        write_register(REG_COUNT, 1);
        send_point(0);
        send_point(1023);
        wait_drained();
        // zero count after masking: everything flagged
        write_register(REG_COUNT, 32'hFFFF_F800);
        send_point(0);
        send_point(1023);
        wait_drained();
        write_register(REG_COUNT, 2047);
        send_point(1023);
        send_point(0);
        wait_drained();
        write_register(REG_COUNT, 32'hFFFF_F802);
        send_point(0);
        send_point(1);
        send_point(2);
        wait_drained();
        // unmapped index must leave the registers alone
        write_register(CFG_UNUSED, 32'hFFFF_FFFF);
        send_point(1);
    endtask

    task automatic test_saturating_controls();
        wait_drained();
        write_register(REG_C1_X, 32'h0001_FFFF);
        write_register(REG_C1_Y, 32'h0001_FFFF);
        write_register(REG_C2_X, CFG_DATA_W'(UNIT + 1));
        write_register(REG_C2_Y, 0);
        write_register(REG_STRIP, X_MAX);
        write_register(REG_BOX, 0);
        write_register(REG_COUNT, 3);
        send_point(0);
        send_point(1);
        send_point(2);
        wait_drained();
        write_register(REG_STRIP, 12345);
        write_register(REG_BOX, 12345);
        send_point(1);
    endtask

    task automatic test_random_curves();
        int sent;
        int phase;
        int phase_len;
        int eff_count;
        int r;
        logic [CFG_DATA_W-1:0] cnt_val;
        logic [IDX_W-1:0] idx;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            if (phase == 0) begin
                // widest span, control points pinned at the far end
                write_register(REG_STRIP, 0);
                write_register(REG_BOX, X_MAX);
                write_register(REG_C1_X, CFG_DATA_W'(UNIT));
                write_register(REG_C1_Y, 0);
                write_register(REG_C2_X, CFG_DATA_W'(UNIT));
                write_register(REG_C2_Y, 0);
                write_register(REG_COUNT, MAX_POINTS);
            end else if (phase == 1) begin
                write_register(REG_STRIP, X_MAX);
                write_register(REG_BOX, 0);
                write_register(REG_C1_X, 0);
                write_register(REG_C1_Y, CFG_DATA_W'(UNIT));
                write_register(REG_C2_X, 0);
                write_register(REG_C2_Y, CFG_DATA_W'(UNIT));
                write_register(REG_COUNT, 2);
            end else begin
                if ($urandom_range(0, 3) != 0) write_register(REG_STRIP, width_value());
                if ($urandom_range(0, 3) != 0) write_register(REG_BOX, width_value());
                if ($urandom_range(0, 3) != 0) write_register(REG_C1_X, frac_value());
                if ($urandom_range(0, 3) != 0) write_register(REG_C1_Y, frac_value());
                if ($urandom_range(0, 3) != 0) write_register(REG_C2_X, frac_value());
                if ($urandom_range(0, 3) != 0) write_register(REG_C2_Y, frac_value());
                if ($urandom_range(0, 3) != 0) begin
                    r = $urandom_range(0, 15);
                    case (r)
                        0:       cnt_val = 0;
                        1:       cnt_val = 1;
                        2:       cnt_val = 2;
                        3:       cnt_val = $urandom_range(MAX_POINTS + 1, 2047);
                        4:       cnt_val = MAX_POINTS;
                        5, 6:    cnt_val = $urandom_range(1, 16);
                        default: cnt_val = $urandom_range(1, MAX_POINTS);
                    endcase
                    if ($urandom_range(0, 3) == 0) cnt_val = cnt_val | ($urandom & ~32'h7FF);
                    write_register(REG_COUNT, cnt_val);
                end
            end
            phase_len = $urandom_range(40, 160);
            if (RANDOM_ITEMS - sent <= 200) begin
                phase_len = RANDOM_ITEMS - sent;
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            eff_count = (cfg_count > MAX_POINTS) ? MAX_POINTS : cfg_count;
            repeat (phase_len) begin
                // mostly indices on the curve, some past the count
                if (eff_count != 0 && $urandom_range(0, 7) != 0)
                    idx = IDX_W'($urandom_range(0, eff_count - 1));
                else
                    idx = IDX_W'($urandom_range(0, 1023));
                send_point(idx);
            end
            sent += phase_len;
            phase++;
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        point_bus.valid    = 1'b0;
        point_bus.payload  = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.payload    = '0;
        result_bus.ready   = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_reset_shape();
        test_count_corners();
        test_saturating_controls();
        test_random_curves();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d curve points (%0d past the count) over %0d register writes",
                 checked, flagged, register_writes);
        $display("covered count corners, saturated controls, reversed spans and random curves");
        if (errors == 0 && pending_points.size() == 0) begin
            $display("cubic_bezier_point_test: PASS");
        end else begin
            $display("cubic_bezier_point_test: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d curve points outstanding", pending_points.size());
        $display("cubic_bezier_point_test: FAIL");
        $finish;
    end

endmodule

// File: files.f
design/cbp_pkg.sv
design/cbp_stream_if.sv
design/cbp_cfg_regs.sv
design/cbp_tdiv.sv
design/cbp_lerp_level.sv
design/cubic_bezier_point.sv
tb/cubic_bezier_point_test.sv
